>>> rtl/sm4_block_cipher_defines.svh
// Assertion macros for the SM4 block cipher RTL.
`ifndef SM4_BLOCK_CIPHER_DEFINES_SVH
`define SM4_BLOCK_CIPHER_DEFINES_SVH

// Property that must hold on every clock edge out of reset.
`define SM4_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SM4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sm4_pkg.sv
// SM4 package: types, constants and round functions.
package sm4_pkg;

    localparam int SM4_ROUNDS = 32;
    localparam logic [4:0] ROUND_LAST = 5'(SM4_ROUNDS - 1);

    localparam logic [1:0] REG_KEY_HIGH     = 2'd0;
    localparam logic [1:0] REG_KEY_LOW      = 2'd1;
    localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

    localparam logic [31:0] FK0 = 32'hA3B1BAC6;
    localparam logic [31:0] FK1 = 32'h56AA3350;
    localparam logic [31:0] FK2 = 32'h677D9197;
    localparam logic [31:0] FK3 = 32'hB27022DC;

    localparam logic [7:0] SM4_SBOX [0:255] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPAND,
        S_LOAD,
        S_ROUND,
        S_OUTPUT
    } sm4_state_t;

    typedef struct packed {
        logic       capture;
        logic       expand_step;
        logic       block_init;
        logic       round_step;
        logic       result_load;
        logic [4:0] count;
        logic [4:0] rd_idx;
    } sm4_cmd_t;

    typedef struct packed {
        logic key_write;
    } sm4_status_t;

    function automatic logic [31:0] sm4_tau(input logic [31:0] v);
        return {SM4_SBOX[v[31:24]], SM4_SBOX[v[23:16]], SM4_SBOX[v[15:8]], SM4_SBOX[v[7:0]]};
    endfunction

    function automatic logic [31:0] sm4_l(input logic [31:0] t);
        return t ^ {t[29:0], t[31:30]} ^ {t[21:0], t[31:22]}
                 ^ {t[13:0], t[31:14]} ^ {t[7:0], t[31:8]};
    endfunction

    function automatic logic [31:0] sm4_lprime(input logic [31:0] t);
        return t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};
    endfunction

    // CK byte j of word i is (4i + j) * 7 mod 256
    function automatic logic [31:0] sm4_ck(input logic [4:0] idx);
        logic [31:0] w;
        logic [7:0]  b;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            b = 8'({1'b0, idx, 2'(j)} * 8'd7);
            w = {w[23:0], b};
        end
        return w;
    endfunction

endpackage

>>> rtl/sm4_ctrl.sv
// SM4 controller: sequencing of key expansion, rounds and output transfer.
`include "sm4_block_cipher_defines.svh"

module sm4_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  sm4_pkg::sm4_status_t status,
    output sm4_pkg::sm4_cmd_t    cmd
);
    import sm4_pkg::*;

    sm4_state_t state_reg, state_next;
    logic [4:0] count_reg, count_next;
    logic       keys_ready_reg, keys_ready_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_xfer;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                    state_next = keys_ready_reg ? S_LOAD : S_EXPAND;
            end
            S_EXPAND:
            begin
                if (count_reg == ROUND_LAST)
                    state_next = S_LOAD;
            end
            S_LOAD:
                state_next = S_ROUND;
            S_ROUND:
            begin
                if (count_reg == ROUND_LAST)
                    state_next = S_OUTPUT;
            end
            S_OUTPUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.count       = count_reg;
        cmd.rd_idx      = count_reg + 5'd1;
        unique case (state_reg)
            S_IDLE:   cmd.capture     = in_xfer;
            S_EXPAND: cmd.expand_step = 1'b1;
            S_LOAD:
            begin
                cmd.block_init = 1'b1;
                cmd.rd_idx     = '0;
            end
            S_ROUND:  cmd.round_step  = 1'b1;
            S_OUTPUT: cmd.result_load = out_free;
            default:  cmd.capture     = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next = '0;
        if (state_reg == S_EXPAND || state_reg == S_ROUND)
            count_next = count_reg + 5'd1;

        keys_ready_next = keys_ready_reg;
        priority if (status.key_write)
            keys_ready_next = 1'b0;
        else if (state_reg == S_EXPAND && count_reg == ROUND_LAST)
            keys_ready_next = 1'b1;

        out_valid_next = out_valid_reg;
        priority if (cmd.result_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            keys_ready_reg <= keys_ready_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    `SM4_ASSERT(a_load_free, !cmd.result_load || !out_valid_reg || out_ready, "result overwrite")
    `SM4_ASSERT(a_expand_stale, !cmd.expand_step || !keys_ready_reg, "expansion with valid keys")
    `SM4_ASSERT_NEXT(a_need_expand, in_xfer && !keys_ready_reg, state_reg == S_EXPAND, "skipped key expansion")
    `SM4_ASSERT_NEXT(a_last_round, state_reg == S_ROUND && count_reg == ROUND_LAST, state_reg == S_OUTPUT, "round count off")

endmodule

>>> rtl/sm4_dp.sv
// SM4 datapath: config registers, round key memory and shared round unit.
module sm4_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic [63:0]          block_high,
    input  logic [63:0]          block_low,
    output logic [63:0]          result_high,
    output logic [63:0]          result_low,
    input  sm4_pkg::sm4_cmd_t    cmd,
    output sm4_pkg::sm4_status_t status
);
    import sm4_pkg::*;

    logic [63:0]  key_high_reg, key_low_reg;
    logic         decrypt_reg;
    logic [127:0] blk_reg;
    logic [31:0]  w_reg [4];
    logic [31:0]  w_next [4];
    logic [31:0]  rk_reg;
    logic [31:0]  rk_mem [SM4_ROUNDS];
    logic [63:0]  res_high_reg, res_low_reg;
    logic [4:0]   rd_addr;
    logic [31:0]  mix, t, nx;

    assign status.key_write = cfg_write
        && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            decrypt_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KEY_HIGH:     key_high_reg <= cfg_data;
                REG_KEY_LOW:      key_low_reg  <= cfg_data;
                REG_DECRYPT_MODE: decrypt_reg  <= cfg_data[0];
                default:          decrypt_reg  <= decrypt_reg;
            endcase
        end
    end

    // decryption walks the keys from the top: 31 - i is ~i on five bits
    assign rd_addr = decrypt_reg ? ~cmd.rd_idx : cmd.rd_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.expand_step)
            rk_mem[cmd.count] <= nx;
        rk_reg <= rk_mem[rd_addr];
    end

    always_comb
    begin
        mix = w_reg[1] ^ w_reg[2] ^ w_reg[3] ^ (cmd.expand_step ? sm4_ck(cmd.count) : rk_reg);
        t   = sm4_tau(mix);
        nx  = w_reg[0] ^ (cmd.expand_step ? sm4_lprime(t) : sm4_l(t));

        w_next = w_reg;
        priority if (cmd.capture)
        begin
            w_next[0] = key_high_reg[63:32] ^ FK0;
            w_next[1] = key_high_reg[31:0]  ^ FK1;
            w_next[2] = key_low_reg[63:32]  ^ FK2;
            w_next[3] = key_low_reg[31:0]   ^ FK3;
        end
        else if (cmd.block_init)
        begin
            w_next[0] = blk_reg[127:96];
            w_next[1] = blk_reg[95:64];
            w_next[2] = blk_reg[63:32];
            w_next[3] = blk_reg[31:0];
        end
        else if (cmd.expand_step || cmd.round_step)
        begin
            w_next[0] = w_reg[1];
            w_next[1] = w_reg[2];
            w_next[2] = w_reg[3];
            w_next[3] = nx;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        if (cmd.capture)
            blk_reg <= {block_high, block_low};
        if (cmd.result_load)
        begin
            res_high_reg <= {w_reg[3], w_reg[2]};
            res_low_reg  <= {w_reg[1], w_reg[0]};
        end
    end

    assign result_high = res_high_reg;
    assign result_low  = res_low_reg;

endmodule

>>> rtl/sm4_block_cipher.sv
// SM4 block cipher top level: one 128-bit block per transfer.
//
// Input channel in_valid/in_ready carries block_high (words X0, X1) and
// block_low (words X2, X3). Output channel out_valid/out_ready carries
// result_high and result_low. The config port (cfg_write, cfg_index,
// cfg_data) writes key_high (0), key_low (1) and decrypt_mode (2); the user
// must write only while idle; the block does not enforce it. A key write
// marks the round keys stale; the next transfer first expands all 32 round
// keys, one per cycle, into the round key memory. Per block: a load state,
// 32 rounds at one round per cycle through the shared round unit (round
// keys registered ahead of use), then the output state loads the output
// register. A new block is taken only after the last one leaves the output
// state. The output register holds a result until taken; a stalled receiver
// keeps the block waiting in its output state and in_ready low. Reset
// clears the key and mode registers and marks the round keys stale.
module sm4_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);
    import sm4_pkg::*;

    sm4_cmd_t    cmd;
    sm4_status_t status;

    sm4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sm4_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .block_high  (block_high),
        .block_low   (block_low),
        .result_high (result_high),
        .result_low  (result_low),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
